/* hdl/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants for the keypad code lock
// Key codes, event codes and the registered item record.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int CODE_LENGTH_DEF = 4;

  localparam logic [7:0]  KEY_NONE    = 8'h00;
  localparam logic [7:0]  KEY_ERASE   = 8'h2A;  // '*'
  localparam logic [7:0]  KEY_ENTER   = 8'h23;  // '#'
  localparam logic [7:0]  CONFIRM_YES = 8'h31;  // '1'
  localparam logic [31:0] CODE_RESET  = 32'h3132_3334;  // "1234"

  typedef enum logic {
    OP_KEY     = 1'b0,
    OP_CONFIRM = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    EV_APPENDED   = 3'd0,
    EV_FULL       = 3'd1,
    EV_ERASED     = 3'd2,
    EV_CODE_RIGHT = 3'd3,
    EV_CODE_WRONG = 3'd4,
    EV_UNLOCKED   = 3'd5,
    EV_REJECTED   = 3'd6,
    EV_IGNORED    = 3'd7
  } event_t;

  typedef struct packed {
    logic       valid;
    logic       operation;
    logic [7:0] key_code;
  } item_t;

endpackage

/* hdl/kcl_if.sv */
// ----------------------------------------------------------------------------
// kcl_if: handshake channels of the keypad code lock
// Input items, result items and the code register write channel.
// ----------------------------------------------------------------------------
interface kcl_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] key_code;

  modport source (output valid, output operation, output key_code, input ready);
  modport sink   (input valid, input operation, input key_code, output ready);
endinterface

interface kcl_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] entry_length;
  logic [7:0] echo_char;

  modport source (output valid, output event_res, output entry_length,
                  output echo_char, input ready);
  modport sink   (input valid, input event_res, input entry_length,
                  input echo_char, output ready);
endinterface

interface kcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;

  modport source (output valid, output code_word, input ready);
  modport sink   (input valid, input code_word, output ready);
endinterface

/* hdl/kcl_in_stage.sv */
// ----------------------------------------------------------------------------
// kcl_in_stage: input register
// Holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module kcl_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  kcl_item_if.sink             item,
  input  logic                 advance,
  output kcl_pkg::item_t       held
);
  import kcl_pkg::*;

  logic       in_valid;
  logic       operation;
  logic [7:0] key_code;
  logic       take;

  assign item.ready = !in_valid || advance;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      operation <= item.operation;
      key_code  <= item.key_code;
    end
  end

  assign held = '{valid: in_valid, operation: operation, key_code: key_code};

endmodule

/* hdl/kcl_engine.sv */
// ----------------------------------------------------------------------------
// kcl_engine: entry state, code compare and result register
// Handles one held item per cycle while result is not stalled, and registers its result.
// ----------------------------------------------------------------------------
module kcl_engine #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kcl_pkg::item_t       held,
  input  logic [31:0]          code_word,
  output logic                 advance,
  kcl_result_if.source         result
);
  import kcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int CMP_N = (CODE_LENGTH < 4) ? CODE_LENGTH : 4;
  localparam int EXT_W = (CNT_W > 3) ? CNT_W : 3;

  logic [7:0]       entered_chars [CODE_LENGTH];
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_count_next;
  logic             awaiting_confirm;
  logic             awaiting_confirm_next;

  logic             res_valid;
  event_t           event_res;
  event_t           event_next;
  logic [2:0]       entry_length;
  logic [7:0]       echo_char;
  logic [7:0]       echo_next;
  logic             wr_en;
  logic [EXT_W-1:0] count_ext;

  logic [CNT_W-1:0] code_len;
  logic             match;

  assign advance = held.valid && (!res_valid || result.ready);

  // Code ends at the first zero byte; only positions inside it must match.
  always_comb begin
    logic prefix;
    prefix   = 1'b1;
    code_len = '0;
    match    = 1'b1;
    for (int i = 0; i < CMP_N; i++) begin
      prefix   = prefix && (code_word[8*(3-i) +: 8] != 8'h00);
      code_len = code_len + CNT_W'(prefix);
      if (prefix && (entered_chars[i] != code_word[8*(3-i) +: 8])) begin
        match = 1'b0;
      end
    end
    if (entry_count != code_len) begin
      match = 1'b0;
    end
  end

  always_comb begin
    event_next            = EV_IGNORED;
    echo_next             = 8'h00;
    entry_count_next      = entry_count;
    awaiting_confirm_next = awaiting_confirm;
    wr_en                 = 1'b0;
    if (awaiting_confirm) begin
      if (held.operation == OP_CONFIRM) begin
        event_next            = (held.key_code == CONFIRM_YES) ? EV_UNLOCKED : EV_REJECTED;
        awaiting_confirm_next = 1'b0;
      end
    end else if (held.operation == OP_KEY && held.key_code != KEY_NONE) begin
      case (held.key_code)
        KEY_ENTER: begin
          event_next            = match ? EV_CODE_RIGHT : EV_CODE_WRONG;
          awaiting_confirm_next = match;
          entry_count_next      = '0;
        end
        KEY_ERASE: begin
          event_next = EV_ERASED;
          if (entry_count != '0) begin
            entry_count_next = entry_count - CNT_W'(1);
          end
        end
        default: begin
          if (entry_count < CNT_W'(CODE_LENGTH)) begin
            event_next       = EV_APPENDED;
            echo_next        = held.key_code;
            entry_count_next = entry_count + CNT_W'(1);
            wr_en            = 1'b1;
          end else begin
            event_next = EV_FULL;
          end
        end
      endcase
    end
  end

  assign count_ext = EXT_W'(entry_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count      <= '0;
      awaiting_confirm <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (advance) begin
        entry_count      <= entry_count_next;
        awaiting_confirm <= awaiting_confirm_next;
        res_valid        <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res    <= event_next;
      entry_length <= count_ext[2:0];
      echo_char    <= echo_next;
    end
    if (advance && wr_en) begin
      entered_chars[entry_count[IDX_W-1:0]] <= held.key_code;
    end
  end

  assign result.valid        = res_valid;
  assign result.event_res    = event_res;
  assign result.entry_length = entry_length;
  assign result.echo_char    = echo_char;

endmodule

/* hdl/keypad_code_lock_top.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock_top: keypad code lock controller
// Input register, entry/compare engine and the code register.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel of keypad keys (operation 0) and link
//            confirmation bytes (operation 1), key_code in ASCII.
//   result : one transfer per item: event_res, entry_length, echo_char.
//   cfg    : write channel for the 32-bit code word, always ready; write it
//            only while no item is in flight.
//   An item passes through the input register, which loads at the item
//   transfer, and then the result register, which loads when the engine
//   takes the item. Throughput is one item per cycle while result is not
//   stalled; the entry state updates in the same cycle the engine takes an
//   item.
//   Reset (rst, synchronous) empties the entry, returns to the entry stage
//   and loads the code "1234". When result is stalled, the result register
//   and then the input register hold; item.ready drops only when both are
//   full, and no result is lost or repeated.
// ----------------------------------------------------------------------------
module keypad_code_lock_top #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  kcl_item_if.sink     item,
  kcl_result_if.source result,
  kcl_cfg_if.sink      cfg
);
  import kcl_pkg::*;

  logic [31:0] code_word;
  logic        advance;
  item_t       held;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_word <= CODE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      code_word <= cfg.code_word;
    end
  end

  kcl_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .held    (held)
  );

  kcl_engine #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .held      (held),
    .code_word (code_word),
    .advance   (advance),
    .result    (result)
  );

endmodule
